/* sv/qrs_pkg.sv */
// qrs_pkg: shared constants and types for the quadratic root solver.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int QRS_COEF_WIDTH = 16;
    localparam int QRS_FRAC_BITS  = 16;
    localparam int QRS_OUT_WIDTH  = 34;
    localparam int QRS_FIFO_DEPTH = 4;

    typedef struct packed {
        logic valid;
        logic a_zero;
        logic d_neg;
    } qrs_ctrl_t;

endpackage

/* sv/quadratic_root_solver.sv */
// quadratic_root_solver: top level; front end, queue, square root, divider
// and output register. Depends on qrs_pkg, qrs_front, qrs_fifo, qrs_sqrt, qrs_div.
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel: one beat carries coefficients a, b, c (signed integers).
//   m_ channel: one beat per input beat, in order: discriminant and the real
//   and imaginary parts of both roots (FRAC_BITS fraction bits); m_tuser is
//   the not-quadratic flag, set when a is zero with all data fields zero.
//   Throughput: one beat per cycle, sustained, while m_tready is high.
//   Pipeline: two front stages, one queue stage, COEF_WIDTH+FRAC_BITS+1
//   square-root stages, one numerator stage, COEF_WIDTH+FRAC_BITS+2 divider
//   stages, one output register.
//   Stall: with m_tvalid high and m_tready low the back end holds; the front
//   end keeps accepting until the four-entry queue fills, then drops s_tready.
//   Reset: synchronous active-low aresetn empties the pipeline and queue.
//
module quadratic_root_solver import qrs_pkg::*; #(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS,
    localparam int ID = ((3 * COEF_WIDTH + 7) / 8) * 8,
    localparam int OD = ((5 * QRS_OUT_WIDTH + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [ID-1:0] s_tdata,  // coef_a, coef_b, coef_c
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [OD-1:0] m_tdata,  // discriminant, root_one_real, root_two_real,
                                    // root_one_imag, root_two_imag
    output logic          m_tuser   // not_quadratic
);

    localparam int CW  = COEF_WIDTH;
    localparam int OW  = QRS_OUT_WIDTH;
    localparam int DW  = 2 * CW + 2;
    localparam int NBW = CW + FRAC_BITS + 1;
    localparam int RT  = CW + FRAC_BITS + 1;
    localparam int NW  = CW + FRAC_BITS + 3;
    localparam int UW  = NW - 1;
    localparam int DM  = CW + 1;
    localparam int QW  = UW + 1;
    localparam int BW  = (QW > OW) ? QW : OW;
    localparam int BDW = (DW > OW) ? DW : OW;
    localparam int FW  = 2 + DW + DW + NBW + CW + 1;
    localparam int SPW = DW + NBW + CW + 1;
    localparam int DPW = DW + 2;

    logic be, fe;

    // front end
    qrs_ctrl_t                f_ctrl;
    logic signed [DW-1:0]     f_disc;
    logic        [DW-1:0]     f_mag;
    logic signed [NBW-1:0]    f_nb;
    logic signed [CW:0]       f_den;

    qrs_front #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (fe),
        .in_valid (s_tvalid),
        .coef_a   (signed'(s_tdata[CW-1:0])),
        .coef_b   (signed'(s_tdata[2*CW-1:CW])),
        .coef_c   (signed'(s_tdata[3*CW-1:2*CW])),
        .ctrl     (f_ctrl),
        .disc     (f_disc),
        .mag      (f_mag),
        .nb       (f_nb),
        .den      (f_den)
    );

    // queue
    logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
    logic [FW-1:0] fifo_din, fifo_dout;

    assign fe        = !fifo_full;
    assign s_tready  = fe;
    assign fifo_push = fe && f_ctrl.valid;
    assign fifo_pop  = be && !fifo_empty;
    assign fifo_din  = {f_ctrl.a_zero, f_ctrl.d_neg, f_disc, f_mag, f_nb, f_den};

    qrs_fifo #(.WIDTH(FW), .DEPTH(QRS_FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fifo_push),
        .din     (fifo_din),
        .pop     (fifo_pop),
        .dout    (fifo_dout),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // square root
    qrs_ctrl_t      q_ctrl;
    logic [DW-1:0]  q_mag;
    logic [SPW-1:0] q_pay;

    assign q_ctrl.valid  = !fifo_empty;
    assign q_ctrl.a_zero = fifo_dout[FW-1];
    assign q_ctrl.d_neg  = fifo_dout[FW-2];
    assign q_mag         = fifo_dout[NBW+CW+1 +: DW];
    assign q_pay         = {fifo_dout[NBW+CW+1+DW +: DW], fifo_dout[NBW+CW:0]};

    qrs_ctrl_t      r_ctrl;
    logic [RT-1:0]  r_root;
    logic [SPW-1:0] r_pay;

    qrs_sqrt #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS), .PAY_W(SPW)) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (be),
        .in_ctrl  (q_ctrl),
        .in_mag   (q_mag),
        .in_pay   (q_pay),
        .out_ctrl (r_ctrl),
        .out_root (r_root),
        .out_pay  (r_pay)
    );

    // numerator forming
    logic signed [DW-1:0]  r_disc;
    logic signed [NBW-1:0] r_nb;
    logic signed [CW:0]    r_den;
    logic signed [NW-1:0]  nbx, sx, n0, n1;

    assign r_disc = signed'(r_pay[SPW-1 -: DW]);
    assign r_nb   = signed'(r_pay[CW+1 +: NBW]);
    assign r_den  = signed'(r_pay[CW:0]);

    always_comb begin
        nbx = NW'(r_nb);
        sx  = signed'(NW'(r_root));
        n0  = r_ctrl.d_neg ? nbx : nbx + sx;
        n1  = r_ctrl.d_neg ? sx : nbx - sx;
    end

    qrs_ctrl_t            p_ctrl_reg;
    logic [UW-1:0]        p_n0_reg, p_n1_reg;
    logic [DM-1:0]        p_dm_reg;
    logic                 p_neg0_reg, p_neg1_reg;
    logic signed [DW-1:0] p_disc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctrl_reg <= '0;
        end else if (be) begin
            p_ctrl_reg <= r_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            p_n0_reg   <= n0[NW-1] ? UW'(-n0) : UW'(n0);
            p_n1_reg   <= n1[NW-1] ? UW'(-n1) : UW'(n1);
            p_dm_reg   <= r_den[CW] ? DM'(-r_den) : DM'(r_den);
            p_neg0_reg <= n0[NW-1] ^ r_den[CW];
            p_neg1_reg <= n1[NW-1] ^ r_den[CW];
            p_disc_reg <= r_disc;
        end
    end

    // division
    qrs_ctrl_t      v_ctrl;
    logic [UW-1:0]  v_q0, v_q1;
    logic [DPW-1:0] v_pay;

    qrs_div #(.UW(UW), .DM(DM), .PAY_W(DPW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (be),
        .in_ctrl  (p_ctrl_reg),
        .num0     (p_n0_reg),
        .num1     (p_n1_reg),
        .den      (p_dm_reg),
        .in_pay   ({p_disc_reg, p_neg0_reg, p_neg1_reg}),
        .out_ctrl (v_ctrl),
        .quo0     (v_q0),
        .quo1     (v_q1),
        .out_pay  (v_pay)
    );

    // output register
    logic signed [QW-1:0]  q0p, q1p, q0s, q1s, q1n;
    logic signed [BW-1:0]  r1w, r2w, i1w, i2w;
    logic signed [BDW-1:0] dw;
    logic                  v_neg0, v_neg1;
    logic [OD-1:0]         m_tdata_next;
    logic                  m_tvalid_reg;
    logic [OD-1:0]         m_tdata_reg;
    logic                  m_tuser_reg;

    assign v_neg0 = v_pay[1];
    assign v_neg1 = v_pay[0];

    always_comb begin
        q0p = signed'({1'b0, v_q0});
        q1p = signed'({1'b0, v_q1});
        q0s = v_neg0 ? -q0p : q0p;
        q1s = v_neg1 ? -q1p : q1p;
        q1n = v_neg1 ? q1p : -q1p;
        dw  = BDW'(signed'(v_pay[DPW-1 -: DW]));
        r1w = BW'(q0s);
        r2w = v_ctrl.d_neg ? BW'(q0s) : BW'(q1s);
        i1w = v_ctrl.d_neg ? BW'(q1s) : '0;
        i2w = v_ctrl.d_neg ? BW'(q1n) : '0;
        if (v_ctrl.a_zero) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = OD'({i2w[OW-1:0], i1w[OW-1:0], r2w[OW-1:0],
                                r1w[OW-1:0], dw[OW-1:0]});
        end
    end

    assign be = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (be) begin
            m_tvalid_reg <= v_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= v_ctrl.a_zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_push && fifo_full))
        else $error("queue written while full");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("non-quadratic beat carries nonzero data");

    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fe && f_ctrl.valid |=> f_ctrl.valid)
        else $error("front item lost while queue full");
`endif

endmodule

/* sv/qrs_front.sv */
// qrs_front: two-stage front end; forms b*b and a*c, then the discriminant,
// its magnitude, -b scaled, 2a and the item class. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_front import qrs_pkg::*; #(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS,
    localparam int DW  = 2 * COEF_WIDTH + 2,
    localparam int NBW = COEF_WIDTH + FRAC_BITS + 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COEF_WIDTH-1:0] coef_a,
    input  logic signed [COEF_WIDTH-1:0] coef_b,
    input  logic signed [COEF_WIDTH-1:0] coef_c,
    output qrs_ctrl_t                    ctrl,
    output logic signed [DW-1:0]         disc,
    output logic        [DW-1:0]         mag,
    output logic signed [NBW-1:0]        nb,
    output logic signed [COEF_WIDTH:0]   den
);

    logic                           v1_reg;
    logic signed [COEF_WIDTH-1:0]   a1_reg;
    logic signed [COEF_WIDTH-1:0]   b1_reg;
    logic signed [2*COEF_WIDTH-1:0] bb1_reg;
    logic signed [2*COEF_WIDTH-1:0] ac1_reg;

    qrs_ctrl_t                    ctrl_reg, ctrl_next;
    logic signed [DW-1:0]         disc_reg, disc_next;
    logic        [DW-1:0]         mag_reg, mag_next;
    logic signed [NBW-1:0]        nb_reg, nb_next;
    logic signed [COEF_WIDTH:0]   den_reg, den_next;

    always_comb begin
        disc_next        = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);
        ctrl_next.valid  = v1_reg;
        ctrl_next.a_zero = (a1_reg == '0);
        ctrl_next.d_neg  = disc_next[DW-1];
        mag_next         = disc_next[DW-1] ? unsigned'(-disc_next) : unsigned'(disc_next);
        nb_next          = -(NBW'(b1_reg) <<< FRAC_BITS);
        den_next         = (COEF_WIDTH + 1)'(a1_reg) <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            ctrl_reg <= '0;
        end else if (en) begin
            v1_reg   <= in_valid;
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= coef_a;
            b1_reg   <= coef_b;
            bb1_reg  <= coef_b * coef_b;
            ac1_reg  <= coef_a * coef_c;
            disc_reg <= disc_next;
            mag_reg  <= mag_next;
            nb_reg   <= nb_next;
            den_reg  <= den_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign disc = disc_reg;
    assign mag  = mag_reg;
    assign nb   = nb_reg;
    assign den  = den_reg;

endmodule

/* sv/qrs_fifo.sv */
// qrs_fifo: small register queue between front and back ends.
// Depends on qrs_pkg for the default depth.
`timescale 1ns / 1ps

module qrs_fifo import qrs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QRS_FIFO_DEPTH,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    assign dout  = mem_reg[rd_reg];
    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);

endmodule

/* sv/qrs_sqrt.sv */
// qrs_sqrt: pipelined square root, one result bit per stage, of |d| scaled
// by 4^FRAC_BITS; carries a side payload. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt import qrs_pkg::*; #(
    parameter int COEF_WIDTH = QRS_COEF_WIDTH,
    parameter int FRAC_BITS  = QRS_FRAC_BITS,
    parameter int PAY_W      = 8,
    localparam int DW = 2 * COEF_WIDTH + 2,
    localparam int RT = COEF_WIDTH + FRAC_BITS + 1,
    localparam int RW = RT + 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  qrs_ctrl_t        in_ctrl,
    input  logic [DW-1:0]    in_mag,
    input  logic [PAY_W-1:0] in_pay,
    output qrs_ctrl_t        out_ctrl,
    output logic [RT-1:0]    out_root,
    output logic [PAY_W-1:0] out_pay
);

    qrs_ctrl_t        ctrl_reg [RT];
    logic [RT-1:0]    root_reg [RT];
    logic [RW-1:0]    rem_reg  [RT];
    logic [DW-1:0]    mag_reg  [RT];
    logic [PAY_W-1:0] pay_reg  [RT];

    for (genvar k = 0; k < RT; k++) begin : g_stage
        localparam int I = RT - 1 - k;
        qrs_ctrl_t        c_in;
        logic [RT-1:0]    root_in;
        logic [RW-1:0]    rem_in;
        logic [DW-1:0]    mag_in;
        logic [PAY_W-1:0] pay_in;
        logic [1:0]       pair;
        logic [RW-1:0]    remx, trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign c_in    = in_ctrl;
            assign root_in = '0;
            assign rem_in  = '0;
            assign mag_in  = in_mag;
            assign pay_in  = in_pay;
        end else begin : g_next
            assign c_in    = ctrl_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign mag_in  = mag_reg[k-1];
            assign pay_in  = pay_reg[k-1];
        end

        if (I >= FRAC_BITS) begin : g_pair
            assign pair = mag_in[2*(I-FRAC_BITS) +: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign remx  = {rem_in[RW-3:0], pair};
        assign trial = {root_in, 2'b01};
        assign ge    = (remx >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg[k] <= '0;
            end else if (en) begin
                ctrl_reg[k] <= c_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_in[RT-2:0], ge};
                rem_reg[k]  <= ge ? remx - trial : remx;
                mag_reg[k]  <= mag_in;
                pay_reg[k]  <= pay_in;
            end
        end
    end

    assign out_ctrl = ctrl_reg[RT-1];
    assign out_root = root_reg[RT-1];
    assign out_pay  = pay_reg[RT-1];

endmodule

/* sv/qrs_div.sv */
// qrs_div: two-lane pipelined restoring divider, one quotient bit per stage,
// shared divisor; carries a side payload. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div import qrs_pkg::*; #(
    parameter int UW    = 34,
    parameter int DM    = 17,
    parameter int PAY_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  qrs_ctrl_t        in_ctrl,
    input  logic [UW-1:0]    num0,
    input  logic [UW-1:0]    num1,
    input  logic [DM-1:0]    den,
    input  logic [PAY_W-1:0] in_pay,
    output qrs_ctrl_t        out_ctrl,
    output logic [UW-1:0]    quo0,
    output logic [UW-1:0]    quo1,
    output logic [PAY_W-1:0] out_pay
);

    qrs_ctrl_t        ctrl_reg [UW];
    logic [UW-1:0]    nq_reg   [UW][2];
    logic [DM-1:0]    rem_reg  [UW][2];
    logic [DM-1:0]    den_reg  [UW];
    logic [PAY_W-1:0] pay_reg  [UW];

    for (genvar k = 0; k < UW; k++) begin : g_stage
        qrs_ctrl_t        c_in;
        logic [DM-1:0]    den_in;
        logic [PAY_W-1:0] pay_in;

        if (k == 0) begin : g_first
            assign c_in   = in_ctrl;
            assign den_in = den;
            assign pay_in = in_pay;
        end else begin : g_next
            assign c_in   = ctrl_reg[k-1];
            assign den_in = den_reg[k-1];
            assign pay_in = pay_reg[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [UW-1:0] nq_in;
            logic [DM-1:0] rem_in;
            logic [DM:0]   t;
            logic          ge;

            if (k == 0) begin : g_first
                assign nq_in  = (l == 0) ? num0 : num1;
                assign rem_in = '0;
            end else begin : g_next
                assign nq_in  = nq_reg[k-1][l];
                assign rem_in = rem_reg[k-1][l];
            end

            assign t  = {rem_in, nq_in[UW-1]};
            assign ge = (t >= {1'b0, den_in});

            always_ff @(posedge aclk) begin
                if (en) begin
                    nq_reg[k][l]  <= {nq_in[UW-2:0], ge};
                    rem_reg[k][l] <= ge ? DM'(t - {1'b0, den_in}) : t[DM-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg[k] <= '0;
            end else if (en) begin
                ctrl_reg[k] <= c_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[k] <= den_in;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_ctrl = ctrl_reg[UW-1];
    assign quo0     = nq_reg[UW-1][0];
    assign quo1     = nq_reg[UW-1][1];
    assign out_pay  = pay_reg[UW-1];

endmodule
